FILE: rtl/core/ffra_pkg.sv
// shared types and constants of the first-fit region allocator
package ffra_pkg;

    // request kinds
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [1:0] ST_IGNORED    = 2'd3;

    // only firmware type one is usable memory
    localparam logic [31:0] USABLE_TYPE = 32'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] addr;
        logic [63:0] length;
        logic [5:0]  align_log2;
        logic [31:0] region_type;
    } ffra_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_addr;
    } ffra_out_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_O_ADDR, S_O_DATA, S_O_CALC, S_O_TEST,
        S_R_ADDR, S_R_DATA, S_X_ADDR, S_X_DATA,
        S_P_ADDR, S_P_DATA, S_SH_ADDR, S_SH_DATA,
        S_F_ADDR, S_F_DATA, S_FS_ADDR, S_FS_DATA,
        S_DONE
    } ffra_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ADD, OP_SETST, OP_NEXT_PHASE,
        OP_ORD, OP_CAND, OP_END, OP_INEXT, OP_JCLR, OP_JINC,
        OP_RRD, OP_XRD, OP_ACCEPT, OP_PRD, OP_SHSTART,
        OP_SHRD, OP_SHWR, OP_INSWR, OP_FRD, OP_FMATCH,
        OP_FSRD, OP_FSWR, OP_FDEC
    } ffra_op_t;

    typedef struct packed {
        ffra_op_t   op;
        logic [1:0] st;
    } ffra_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       phase;
        logic       found;
        logic       full;
        logic       i_ge_r;
        logic       i_ge_e;
        logic       j_ge_r;
        logic       j_ge_e;
        logic       i_eq_j;
        logic       cand_v;
        logic       in_region;
        logic       conflict;
        logic       le_best;
        logic       match;
    } ffra_stat_t;

endpackage

FILE: rtl/core/first_fit_region_allocator_top.sv
// top level of the first-fit region allocator
//
//  channel   handshake          payload
//  request   start / busy       req  (ffra_in_t)
//  result    done strobe        rsp  (ffra_out_t)
//  config    cfg_we             cfg_wdata (kernel end)
//
// add and unknown requests pass from idle through dispatch to the done beat.
// allocate (unless the extent table is full) walks every candidate (regions then
// extents) and checks each against the regions and extents through one read port
// per table, with an address state and a data state per read; free walks the extents.
// reset clears both tables' counts; no clearing pass runs.
// the result beat lasts one cycle and cannot be stalled.
module first_fit_region_allocator_top
    import ffra_pkg::*;
#(
    parameter int MAX_EXTENTS = 1024,
    parameter int MAX_REGIONS = 32,
    parameter int ADDR_WIDTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ffra_in_t    req,
    output logic        done,
    output ffra_out_t   rsp,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata
);

    ffra_cmd_t  cmd;
    ffra_stat_t stat;

    // sequencer
    ffra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // tables and arithmetic
    ffra_datapath #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done beat outside a busy request");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not go busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("done beat repeated");
`endif

endmodule

FILE: rtl/core/ffra_ram.sv
// generic simple dual-port ram with registered read
module ffra_ram
    import ffra_pkg::*;
#(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ffra_datapath.sv
// allocator datapath: tables, counters, candidate arithmetic
module ffra_datapath
    import ffra_pkg::*;
#(
    parameter int MAX_EXTENTS = 1024,
    parameter int MAX_REGIONS = 32,
    parameter int ADDR_WIDTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  ffra_in_t    req,
    input  ffra_cmd_t   cmd,
    output ffra_stat_t  stat,
    output ffra_out_t   rsp
);

    localparam int AW  = ADDR_WIDTH;
    localparam int RAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int EAW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int RCW = $clog2(MAX_REGIONS + 1);
    localparam int ECW = $clog2(MAX_EXTENTS + 1);
    localparam int IW  = (RCW > ECW) ? RCW : ECW;

    logic [AW-1:0]  kend_reg;
    logic [1:0]     kind_reg;
    logic [AW-1:0]  addr_reg, len_reg, mask_reg;
    logic [31:0]    rtype_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [ECW-1:0] ecnt_reg;
    logic [IW-1:0]  i_reg, j_reg;
    logic           phase_reg, found_reg, v1_reg, cand_v_reg;
    logic [AW-1:0]  a_reg, e_reg, best_reg, beste_reg;
    logic [1:0]     st_reg;

    logic [AW-1:0]   mask_c;
    logic [AW:0]     sum_c, add_sum_c;
    logic [AW-1:0]   rs_start, rs_stop, xs_start, xs_stop, cand_c, t_c, s_c;
    logic [2*AW-1:0] r_rdata, x_rdata, x_wdata;
    logic            r_we, x_we;
    logic [RAW-1:0]  r_raddr;
    logic [EAW-1:0]  x_raddr, x_waddr;
    logic [IW-1:0]   im1, jm1;
    logic            add_ok;

    assign im1 = i_reg - 1'b1;
    assign jm1 = j_reg - 1'b1;
    assign rs_start = r_rdata[2*AW-1:AW];
    assign rs_stop  = r_rdata[AW-1:0];
    assign xs_start = x_rdata[2*AW-1:AW];
    assign xs_stop  = x_rdata[AW-1:0];

    // alignment mask from the exponent
    always_comb
    begin
        for (int k = 0; k < AW; k++)
        begin
            mask_c[k] = (k < int'(req.align_log2));
        end
    end

    // candidate comes from a region start or an extent stop
    assign cand_c = phase_reg ? xs_stop : rs_start;
    assign sum_c  = {1'b0, cand_c} + {1'b0, mask_reg};

    // region add: saturating end and kernel clip
    assign add_sum_c = {1'b0, req.addr[AW-1:0]} + {1'b0, req.length[AW-1:0]};
    assign t_c = add_sum_c[AW] ? {AW{1'b1}} : add_sum_c[AW-1:0];
    assign s_c = (req.addr[AW-1:0] <= kend_reg && kend_reg <= t_c)
                 ? kend_reg : req.addr[AW-1:0];
    assign add_ok = (rtype_reg == USABLE_TYPE) && (addr_reg != '0)
                    && (rcnt_reg < RCW'(MAX_REGIONS));

    // ram address and write muxes
    always_comb
    begin
        r_raddr = (cmd.op == OP_RRD) ? j_reg[RAW-1:0] : i_reg[RAW-1:0];
        r_we    = (cmd.op == OP_ADD) && add_ok;
        x_we    = 1'b0;
        x_waddr = j_reg[EAW-1:0];
        x_wdata = x_rdata;
        x_raddr = i_reg[EAW-1:0];
        unique case (cmd.op)
            OP_XRD, OP_PRD, OP_FSRD: x_raddr = j_reg[EAW-1:0];
            OP_SHRD:                 x_raddr = im1[EAW-1:0];
            default:                 x_raddr = i_reg[EAW-1:0];
        endcase
        unique case (cmd.op)
            OP_SHWR:
            begin
                x_we    = 1'b1;
                x_waddr = i_reg[EAW-1:0];
            end
            OP_INSWR:
            begin
                x_we    = 1'b1;
                x_wdata = {best_reg, beste_reg};
            end
            OP_FSWR:
            begin
                x_we    = 1'b1;
                x_waddr = jm1[EAW-1:0];
            end
            default: x_we = 1'b0;
        endcase
    end

    // add latches the request at load; region written from latched copy
    logic [AW-1:0] s_reg, t_reg;

    ffra_ram #(.WIDTH(2*AW), .DEPTH(MAX_REGIONS)) u_region_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (rcnt_reg[RAW-1:0]),
        .wdata ({s_reg, t_reg}),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    ffra_ram #(.WIDTH(2*AW), .DEPTH(MAX_EXTENTS)) u_extent_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (x_wdata),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kend_reg  <= '0;
            rcnt_reg  <= '0;
            ecnt_reg  <= '0;
            st_reg    <= ST_OK;
            kind_reg  <= REQ_ADD;
            i_reg     <= '0;
            j_reg     <= '0;
            phase_reg <= 1'b0;
            found_reg <= 1'b0;
            v1_reg    <= 1'b0;
            cand_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                kend_reg <= cfg_wdata[AW-1:0];
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    kind_reg  <= req.req_type;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    phase_reg <= 1'b0;
                    found_reg <= 1'b0;
                end
                OP_ADD:
                begin
                    if (add_ok)
                    begin
                        rcnt_reg <= rcnt_reg + 1'b1;
                        st_reg   <= ST_OK;
                    end
                    else
                    begin
                        st_reg <= ST_IGNORED;
                    end
                end
                OP_SETST:      st_reg <= cmd.st;
                OP_NEXT_PHASE:
                begin
                    phase_reg <= 1'b1;
                    i_reg     <= '0;
                end
                OP_CAND:       v1_reg <= !sum_c[AW];
                OP_END:
                begin
                    cand_v_reg <= v1_reg && !({1'b0, a_reg} + {1'b0, len_reg} > {1'b0, {AW{1'b1}}})
                                  && !(found_reg && a_reg >= best_reg);
                    j_reg <= '0;
                end
                OP_INEXT:      i_reg <= i_reg + 1'b1;
                OP_JCLR:       j_reg <= '0;
                OP_JINC:       j_reg <= j_reg + 1'b1;
                OP_ACCEPT:
                begin
                    found_reg <= 1'b1;
                    i_reg     <= i_reg + 1'b1;
                end
                OP_SHSTART:    i_reg <= IW'(ecnt_reg);
                OP_SHWR:       i_reg <= im1;
                OP_INSWR:
                begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    st_reg   <= ST_OK;
                end
                OP_FMATCH:     j_reg <= i_reg + 1'b1;
                OP_FSWR:       j_reg <= j_reg + 1'b1;
                OP_FDEC:
                begin
                    ecnt_reg <= ecnt_reg - 1'b1;
                    st_reg   <= ST_OK;
                end
                default:       st_reg <= st_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                addr_reg  <= req.addr[AW-1:0];
                len_reg   <= req.length[AW-1:0];
                mask_reg  <= mask_c;
                rtype_reg <= req.region_type;
                s_reg     <= s_c;
                t_reg     <= t_c;
            end
            OP_CAND:   a_reg <= sum_c[AW-1:0] & ~mask_reg;
            OP_END:    e_reg <= a_reg + len_reg;
            OP_ACCEPT:
            begin
                best_reg  <= a_reg;
                beste_reg <= e_reg;
            end
            default:   a_reg <= a_reg;
        endcase
    end

    // status toward the controller
    always_comb
    begin
        stat.kind      = kind_reg;
        stat.phase     = phase_reg;
        stat.found     = found_reg;
        stat.full      = (ecnt_reg >= ECW'(MAX_EXTENTS));
        stat.i_ge_r    = (i_reg >= IW'(rcnt_reg));
        stat.i_ge_e    = (i_reg >= IW'(ecnt_reg));
        stat.j_ge_r    = (j_reg >= IW'(rcnt_reg));
        stat.j_ge_e    = (j_reg >= IW'(ecnt_reg));
        stat.i_eq_j    = (i_reg == j_reg);
        stat.cand_v    = cand_v_reg;
        stat.in_region = (a_reg >= rs_start) && (e_reg <= rs_stop);
        stat.conflict  = ((a_reg < xs_stop) && (e_reg > xs_start))
                         || ((a_reg == e_reg) && (a_reg > xs_start) && (a_reg < xs_stop));
        stat.le_best   = (xs_start <= best_reg);
        stat.match     = (xs_start == addr_reg);
    end

    // result beat
    assign rsp.status      = st_reg;
    assign rsp.result_addr = ((st_reg == ST_OK) && (kind_reg == REQ_ALLOC))
                             ? 64'(best_reg) : 64'd0;

endmodule

FILE: rtl/core/ffra_ctrl.sv
// allocator controller state machine
module ffra_ctrl
    import ffra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ffra_stat_t stat,
    output ffra_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    ffra_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.st     = ST_OK;
        busy       = (state_reg != S_IDLE);
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.kind)
                    REQ_ADD:
                    begin
                        cmd.op     = OP_ADD;
                        state_next = S_DONE;
                    end
                    REQ_ALLOC:
                    begin
                        if (stat.full)
                        begin
                            cmd.op     = OP_SETST;
                            cmd.st     = ST_ALLOC_FAIL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_O_ADDR;
                        end
                    end
                    REQ_FREE: state_next = S_F_ADDR;
                    default:
                    begin
                        cmd.op     = OP_SETST;
                        cmd.st     = ST_IGNORED;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_O_ADDR:
            begin
                if (!stat.phase && stat.i_ge_r)
                begin
                    cmd.op = OP_NEXT_PHASE;
                end
                else if (stat.phase && stat.i_ge_e)
                begin
                    if (stat.found)
                    begin
                        cmd.op     = OP_JCLR;
                        state_next = S_P_ADDR;
                    end
                    else
                    begin
                        cmd.op     = OP_SETST;
                        cmd.st     = ST_ALLOC_FAIL;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.op     = OP_ORD;
                    state_next = S_O_DATA;
                end
            end
            S_O_DATA:
            begin
                cmd.op     = OP_CAND;
                state_next = S_O_CALC;
            end
            S_O_CALC:
            begin
                cmd.op     = OP_END;
                state_next = S_O_TEST;
            end
            S_O_TEST:
            begin
                if (stat.cand_v)
                begin
                    state_next = S_R_ADDR;
                end
                else
                begin
                    cmd.op     = OP_INEXT;
                    state_next = S_O_ADDR;
                end
            end
            S_R_ADDR:
            begin
                if (stat.j_ge_r)
                begin
                    cmd.op     = OP_INEXT;
                    state_next = S_O_ADDR;
                end
                else
                begin
                    cmd.op     = OP_RRD;
                    state_next = S_R_DATA;
                end
            end
            S_R_DATA:
            begin
                if (stat.in_region)
                begin
                    cmd.op     = OP_JCLR;
                    state_next = S_X_ADDR;
                end
                else
                begin
                    cmd.op     = OP_JINC;
                    state_next = S_R_ADDR;
                end
            end
            S_X_ADDR:
            begin
                if (stat.j_ge_e)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_O_ADDR;
                end
                else
                begin
                    cmd.op     = OP_XRD;
                    state_next = S_X_DATA;
                end
            end
            S_X_DATA:
            begin
                if (stat.conflict)
                begin
                    cmd.op     = OP_INEXT;
                    state_next = S_O_ADDR;
                end
                else
                begin
                    cmd.op     = OP_JINC;
                    state_next = S_X_ADDR;
                end
            end
            S_P_ADDR:
            begin
                if (stat.j_ge_e)
                begin
                    cmd.op     = OP_SHSTART;
                    state_next = S_SH_ADDR;
                end
                else
                begin
                    cmd.op     = OP_PRD;
                    state_next = S_P_DATA;
                end
            end
            S_P_DATA:
            begin
                if (stat.le_best)
                begin
                    cmd.op     = OP_JINC;
                    state_next = S_P_ADDR;
                end
                else
                begin
                    cmd.op     = OP_SHSTART;
                    state_next = S_SH_ADDR;
                end
            end
            S_SH_ADDR:
            begin
                if (stat.i_eq_j)
                begin
                    cmd.op     = OP_INSWR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SHRD;
                    state_next = S_SH_DATA;
                end
            end
            S_SH_DATA:
            begin
                cmd.op     = OP_SHWR;
                state_next = S_SH_ADDR;
            end
            S_F_ADDR:
            begin
                if (stat.i_ge_e)
                begin
                    cmd.op     = OP_SETST;
                    cmd.st     = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_FRD;
                    state_next = S_F_DATA;
                end
            end
            S_F_DATA:
            begin
                if (stat.match)
                begin
                    cmd.op     = OP_FMATCH;
                    state_next = S_FS_ADDR;
                end
                else
                begin
                    cmd.op     = OP_INEXT;
                    state_next = S_F_ADDR;
                end
            end
            S_FS_ADDR:
            begin
                if (stat.j_ge_e)
                begin
                    cmd.op     = OP_FDEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_FSRD;
                    state_next = S_FS_DATA;
                end
            end
            S_FS_DATA:
            begin
                cmd.op     = OP_FSWR;
                state_next = S_FS_ADDR;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: test/tb.sv
// self-checking testbench for the first-fit region allocator
module tb
    import ffra_pkg::*;
();

    localparam logic [63:0] AMAX        = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          N_REGIONS   = 32;
    localparam int          N_EXTENTS   = 1024;
    localparam int          STALL_LIMIT = 400000;
    localparam int          RANDOM_ITEMS = 480;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    ffra_in_t    req;
    logic        done;
    ffra_out_t   rsp;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    // predicted allocator state
    logic [63:0] kend;
    logic [63:0] reg_lo [N_REGIONS];
    logic [63:0] reg_hi [N_REGIONS];
    int          n_regions;
    logic [63:0] ext_lo [N_EXTENTS];
    logic [63:0] ext_hi [N_EXTENTS];
    int          n_ext;

    ffra_out_t   pending_rsp [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    logic        no_gaps;

    first_fit_region_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // can len bytes sit at the aligned form of c, inside a region and clear of extents
    function automatic logic fits_at(input logic [63:0] c, input logic [63:0] mask,
                                     input logic [63:0] len, output logic [63:0] at);
        logic [63:0] a;
        logic [63:0] e;
        logic        in_region;
        at = '0;
        if (c > AMAX - mask)
            return 1'b0;
        a = (c + mask) & ~mask;
        if (len > AMAX - a)
            return 1'b0;
        e = a + len;
        in_region = 1'b0;
        for (int i = 0; i < n_regions; i++)
            if (a >= reg_lo[i] && e <= reg_hi[i])
                in_region = 1'b1;
        if (!in_region)
            return 1'b0;
        for (int i = 0; i < n_ext; i++)
        begin
            if (a < ext_hi[i] && e > ext_lo[i])
                return 1'b0;
            if (a == e && a > ext_lo[i] && a < ext_hi[i])
                return 1'b0;
        end
        at = a;
        return 1'b1;
    endfunction

    // apply one request to the predicted tables and return its result
    function automatic ffra_out_t apply_request(input ffra_in_t it);
        ffra_out_t   r;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] mask;
        logic [63:0] best;
        logic [63:0] cand;
        logic        found;
        int          pos;
        int          hit;
        r.status      = ST_OK;
        r.result_addr = '0;
        best  = '0;
        found = 1'b0;
        case (it.req_type)
            REQ_ADD:
            begin
                if (it.region_type != USABLE_TYPE || it.addr == '0 || n_regions >= N_REGIONS)
                    r.status = ST_IGNORED;
                else
                begin
                    s = it.addr;
                    t = (it.length > AMAX - it.addr) ? AMAX : it.addr + it.length;
                    if (s <= kend && kend <= t)
                        s = kend;
                    reg_lo[n_regions] = s;
                    reg_hi[n_regions] = t;
                    n_regions++;
                end
            end
            REQ_ALLOC:
            begin
                if (n_ext >= N_EXTENTS)
                    r.status = ST_ALLOC_FAIL;
                else
                begin
                    mask = (64'd1 << it.align_log2) - 64'd1;
                    for (int i = 0; i < n_regions; i++)
                        if (fits_at(reg_lo[i], mask, it.length, cand) && (!found || cand < best))
                        begin
                            best  = cand;
                            found = 1'b1;
                        end
                    for (int i = 0; i < n_ext; i++)
                        if (fits_at(ext_hi[i], mask, it.length, cand) && (!found || cand < best))
                        begin
                            best  = cand;
                            found = 1'b1;
                        end
                    if (!found)
                        r.status = ST_ALLOC_FAIL;
                    else
                    begin
                        pos = 0;
                        while (pos < n_ext && ext_lo[pos] <= best)
                            pos++;
                        for (int i = n_ext; i > pos; i--)
                        begin
                            ext_lo[i] = ext_lo[i-1];
                            ext_hi[i] = ext_hi[i-1];
                        end
                        ext_lo[pos] = best;
                        ext_hi[pos] = best + it.length;
                        n_ext++;
                        r.result_addr = best;
                    end
                end
            end
            REQ_FREE:
            begin
                hit = -1;
                for (int i = 0; i < n_ext; i++)
                    if (hit < 0 && ext_lo[i] == it.addr)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = hit + 1; j < n_ext; j++)
                    begin
                        ext_lo[j-1] = ext_lo[j];
                        ext_hi[j-1] = ext_hi[j];
                    end
                    n_ext--;
                end
            end
            default:
                r.status = ST_IGNORED;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // send one request beat, sometimes with a random gap before it
    task automatic send_request(input ffra_in_t it);
        int gap;
        gap = (!no_gaps && $urandom_range(0, 99) < 13) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= it;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_rsp.push_back(apply_request(it));
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [63:0] a,
                               input logic [63:0] len, input logic [5:0] al,
                               input logic [31:0] rtype);
        ffra_in_t it;
        it.req_type    = kind;
        it.addr        = a;
        it.length      = len;
        it.align_log2  = al;
        it.region_type = rtype;
        send_request(it);
    endtask

    // stop sending and let every outstanding result arrive
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // kernel end write, only while the block is idle
    task automatic write_kernel_end(input logic [63:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        kend = value;
    endtask

    // random request biased toward well-formed traffic in a small address window
    task automatic send_random;
        int          pick;
        logic [63:0] a;
        logic [63:0] len;
        logic [5:0]  al;
        logic [31:0] rtype;
        logic [1:0]  kind;
        pick  = $urandom_range(0, 99);
        a     = {$urandom, $urandom};
        len   = {$urandom, $urandom};
        al    = 6'($urandom);
        rtype = $urandom;
        if (pick < 8)
            kind = 2'($urandom);
        else if (pick < 22 || n_regions < 3)
        begin
            kind = REQ_ADD;
            if (n_regions < 8 && $urandom_range(0, 3) != 0)
            begin
                a     = 64'h1000 * $urandom_range(1, 64);
                len   = 64'($urandom_range(16'h100, 16'h8000));
                rtype = USABLE_TYPE;
            end
            else if ($urandom_range(0, 1) == 0)
                rtype = USABLE_TYPE + 32'($urandom_range(1, 9));
            else
                a = '0;
        end
        else if (pick < 62 && n_ext < 20)
        begin
            kind = REQ_ALLOC;
            if ($urandom_range(0, 9) != 0)
            begin
                len = 64'($urandom_range(0, 16'h600));
                al  = 6'($urandom_range(0, 9));
            end
        end
        else
        begin
            kind = REQ_FREE;
            if (n_ext > 0 && $urandom_range(0, 5) != 0)
                a = ext_lo[$urandom_range(0, n_ext - 1)];
            else if ($urandom_range(0, 1) == 0)
                a = 64'h1000 * $urandom_range(1, 64);
        end
        send_fields(kind, a, len, al, rtype);
    endtask

    task automatic test_region_rules;
        write_kernel_end(64'h8000);
        send_fields(REQ_ADD, 64'h4000, 64'h2000, 6'd0, 32'd2);
        send_fields(REQ_ADD, 64'h4000, 64'h2000, 6'd0, 32'hFFFF_FFFF);
        send_fields(REQ_ADD, 64'h0, 64'h2000, 6'd0, USABLE_TYPE);
        send_fields(REQ_ADD, 64'h6000, 64'h4000, 6'd0, USABLE_TYPE);
        send_fields(REQ_ADD, 64'h10000, 64'h1000, 6'd0, USABLE_TYPE);
        send_fields(REQ_ADD, AMAX - 64'hFFF, AMAX, 6'd0, USABLE_TYPE);
        send_fields(2'd3, AMAX, AMAX, 6'd63, 32'hFFFF_FFFF);
        write_kernel_end(64'h0);
        send_fields(REQ_ADD, 64'h1, 64'h7FF, 6'd0, USABLE_TYPE);
    endtask

    task automatic test_alloc_edges;
        send_fields(REQ_ALLOC, '0, 64'h0, 6'd0, '0);
        send_fields(REQ_ALLOC, '0, 64'h0, 6'd0, '0);
        send_fields(REQ_ALLOC, '0, 64'h100, 6'd4, '0);
        send_fields(REQ_ALLOC, '0, 64'h10, 6'd63, '0);
        send_fields(REQ_ALLOC, '0, AMAX, 6'd0, '0);
        send_fields(REQ_ALLOC, '0, 64'h1000, 6'd12, '0);
        send_fields(REQ_ALLOC, '0, 64'hFFF, 6'd0, '0);
        send_fields(REQ_ALLOC, '0, 64'h3000, 6'd0, '0);
        send_fields(REQ_FREE, 64'h8000, '0, 6'd0, '0);
        send_fields(REQ_FREE, 64'h8000, '0, 6'd0, '0);
        send_fields(REQ_FREE, 64'h5, '0, 6'd0, '0);
        send_fields(REQ_FREE, AMAX, '0, 6'd0, '0);
        send_fields(REQ_ALLOC, AMAX, 64'h20, 6'd5, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= 200 && n < 320);
            if (n == 180)
                write_kernel_end(AMAX);
            if (n == 360)
                write_kernel_end(64'h1000 * $urandom_range(1, 64) + 64'($urandom_range(0, 4095)));
            send_random();
        end
        no_gaps = 1'b0;
    endtask

    // fill the region table to its limit with few extents live
    task automatic test_region_table_full;
        while (n_ext > 4)
            send_fields(REQ_FREE, ext_lo[0], '0, 6'd0, '0);
        repeat (N_REGIONS + 2 - n_regions)
            send_fields(REQ_ADD, 64'h100000 * $urandom_range(1, 200), 64'h800, 6'd0, USABLE_TYPE);
        for (int n = 0; n < 6; n++)
            send_fields(REQ_ALLOC, '0, 64'($urandom_range(1, 16'h400)), 6'd3, '0);
    endtask

    // result checking and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    if (rsp.status !== pending_rsp[0].status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, pending_rsp[0].status));
                    if (rsp.result_addr !== pending_rsp[0].result_addr)
                        report_mismatch($sformatf("result_addr %h, expected %h",
                                                  rsp.result_addr, pending_rsp[0].result_addr));
                    void'(pending_rsp.pop_front());
                end
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL first_fit_region_allocator_top");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        no_gaps      = 1'b0;
        kend         = '0;
        n_regions    = 0;
        n_ext        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_region_rules();
        test_alloc_edges();
        test_random_traffic();
        test_region_table_full();
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS first_fit_region_allocator_top");
        else
            $display("FAIL first_fit_region_allocator_top");
        $finish;
    end

endmodule

FILE: first_fit_region_allocator_top.f
rtl/core/ffra_pkg.sv
rtl/core/ffra_ram.sv
rtl/core/ffra_datapath.sv
rtl/core/ffra_ctrl.sv
rtl/core/first_fit_region_allocator_top.sv
test/tb.sv
